>>> hw/rtl/tsq_pkg.sv
// Shared types, constants and arithmetic helpers for the touch sample qualifier.
// Used by tsq_cfg_regs and touch_sample_qualifier_core; depends on nothing else.
package tsq_pkg;

  localparam int unsigned SampleBits  = 12;
  localparam int unsigned HoldBits    = 4;
  localparam int unsigned RegionBits  = 3;
  localparam int unsigned NumRegs     = 8;
  localparam int unsigned IdxBits     = $clog2(NumRegs);
  localparam int unsigned AddrBits    = IdxBits + 2;
  localparam int unsigned ApbDataBits = 32;

  // Stream payload widths, rounded up to whole bytes.
  localparam int unsigned InDataBits  = ((3 * SampleBits + 7) / 8) * 8;
  localparam int unsigned OutDataBits = ((3 * SampleBits + RegionBits + 7) / 8) * 8;

  // Divide by 100 as multiply by a rounded-up reciprocal and shift.
  localparam int unsigned DivShift = SampleBits + 7;
  localparam int unsigned MultBits = SampleBits + 1;
  localparam int unsigned DivMult  = (2 ** DivShift + 99) / 100;
  localparam int unsigned QuotBits = SampleBits - 6;
  localparam int unsigned ProdBits = SampleBits + MultBits;

  // Region thresholds on divided values.
  localparam int unsigned ZMin      = 8;
  localparam int unsigned XDownMax  = 8;
  localparam int unsigned XUpMin    = 33;
  localparam int unsigned YRightMax = 10;
  localparam int unsigned YCenterLo = 16;
  localparam int unsigned YCenterHi = 23;
  localparam int unsigned YLeftMin  = 32;

  // Register reset values.
  localparam int unsigned XFloorRst     = 510;
  localparam int unsigned YCeilingRst   = 3700;
  localparam int unsigned YClampRst     = 3900;
  localparam int unsigned ZFloorRst     = 200;
  localparam int unsigned TolXRst       = 100;
  localparam int unsigned TolYRst       = 500;
  localparam int unsigned TolZRst       = 100;
  localparam int unsigned HoldLimitRst  = 5;
  localparam int unsigned RunCountMax   = 2 ** HoldBits - 1;

  typedef logic [SampleBits-1:0] sample_t;
  typedef logic [QuotBits-1:0]   quot_t;
  typedef logic [HoldBits-1:0]   hold_t;

  typedef enum logic [IdxBits-1:0] {
    RegXFloor    = 3'd0,
    RegYCeiling  = 3'd1,
    RegYClamp    = 3'd2,
    RegZFloor    = 3'd3,
    RegTolX      = 3'd4,
    RegTolY      = 3'd5,
    RegTolZ      = 3'd6,
    RegHoldLimit = 3'd7
  } reg_idx_e;

  typedef enum logic [RegionBits-1:0] {
    RegionNone       = 3'd0,
    RegionCenterDown = 3'd1,
    RegionCenterUp   = 3'd2,
    RegionRightUp    = 3'd3,
    RegionRightDown  = 3'd4,
    RegionLeftUp     = 3'd5,
    RegionLeftDown   = 3'd6
  } region_e;

  typedef struct packed {
    sample_t x_floor;
    sample_t y_ceiling;
    sample_t y_clamp_value;
    sample_t z_floor;
    sample_t tol_x;
    sample_t tol_y;
    sample_t tol_z;
    hold_t   hold_limit;
  } cfg_t;

  function automatic quot_t div100(sample_t v);
    logic [ProdBits-1:0] prod;
    prod = ProdBits'(v) * ProdBits'(MultBits'(DivMult));
    return prod[DivShift +: QuotBits];
  endfunction

  function automatic region_e classify(quot_t x, quot_t y, quot_t z);
    logic down, up, right, center, left;
    region_e r;
    down   = 32'(x) <= XDownMax;
    up     = 32'(x) >= XUpMin;
    right  = 32'(y) <= YRightMax;
    center = (32'(y) >= YCenterLo) && (32'(y) <= YCenterHi);
    left   = 32'(y) >= YLeftMin;
    r      = RegionNone;
    if (32'(z) >= ZMin) begin
      if (down) begin
        if (right)       r = RegionRightDown;
        else if (center) r = RegionCenterDown;
        else if (left)   r = RegionLeftDown;
      end else if (up) begin
        if (right)       r = RegionRightUp;
        else if (center) r = RegionCenterUp;
        else if (left)   r = RegionLeftUp;
      end
    end
    return r;
  endfunction

endpackage

>>> hw/rtl/tsq_cfg_regs.sv
// APB register file for the touch sample qualifier thresholds and windows.
// Depends on tsq_pkg.
module tsq_cfg_regs (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [tsq_pkg::AddrBits-1:0]  paddr,
  input  logic [tsq_pkg::ApbDataBits-1:0] pwdata,
  output logic [tsq_pkg::ApbDataBits-1:0] prdata,
  output logic                          pready,
  output tsq_pkg::cfg_t                 cfg_o
);
  import tsq_pkg::*;

  cfg_t     cfg_q;
  logic     wr_en;
  reg_idx_e idx;
  sample_t  wval;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;
  assign idx    = reg_idx_e'(paddr[AddrBits-1:2]);
  assign wval   = pwdata[SampleBits-1:0];
  assign cfg_o  = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.x_floor       <= SampleBits'(XFloorRst);
      cfg_q.y_ceiling     <= SampleBits'(YCeilingRst);
      cfg_q.y_clamp_value <= SampleBits'(YClampRst);
      cfg_q.z_floor       <= SampleBits'(ZFloorRst);
      cfg_q.tol_x         <= SampleBits'(TolXRst);
      cfg_q.tol_y         <= SampleBits'(TolYRst);
      cfg_q.tol_z         <= SampleBits'(TolZRst);
      cfg_q.hold_limit    <= HoldBits'(HoldLimitRst);
    end else if (wr_en) begin
      unique case (idx)
        RegXFloor:    cfg_q.x_floor       <= wval;
        RegYCeiling:  cfg_q.y_ceiling     <= wval;
        RegYClamp:    cfg_q.y_clamp_value <= wval;
        RegZFloor:    cfg_q.z_floor       <= wval;
        RegTolX:      cfg_q.tol_x         <= wval;
        RegTolY:      cfg_q.tol_y         <= wval;
        RegTolZ:      cfg_q.tol_z         <= wval;
        RegHoldLimit: cfg_q.hold_limit    <= pwdata[HoldBits-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    unique case (idx)
      RegXFloor:    prdata = ApbDataBits'(cfg_q.x_floor);
      RegYCeiling:  prdata = ApbDataBits'(cfg_q.y_ceiling);
      RegYClamp:    prdata = ApbDataBits'(cfg_q.y_clamp_value);
      RegZFloor:    prdata = ApbDataBits'(cfg_q.z_floor);
      RegTolX:      prdata = ApbDataBits'(cfg_q.tol_x);
      RegTolY:      prdata = ApbDataBits'(cfg_q.tol_y);
      RegTolZ:      prdata = ApbDataBits'(cfg_q.tol_z);
      RegHoldLimit: prdata = ApbDataBits'(cfg_q.hold_limit);
      default:      prdata = '0;
    endcase
  end

endmodule

>>> hw/rtl/touch_sample_qualifier_core.sv
// Touch sample qualifier: top level with input register, qualify logic and
// result register. Depends on tsq_pkg and tsq_cfg_regs.
//
// Usage:
//   s_axis carries one raw sample per request: tdata holds raw_x, raw_y, raw_z.
//   m_axis returns one result per sample: tdata holds out_x, out_y, out_z and
//   region; tuser holds the reported flag.
//   The APB port sets clamp floors, windows and the hold limit; write it only
//   while no sample is in flight.
// Path: a sample passes the input register, then the result register, before
//   its result is valid. Throughput: one sample per cycle while m_axis_tready
//   stays high; the start point and run counter update in the same cycle the
//   sample moves into the result register, so the next sample always sees them.
// Reset: registers go to their documented defaults, start point and run count
//   to zero, both pipeline stages empty.
// Stall: when m_axis_tready is low the result holds; the input register keeps
//   one more sample, after which s_axis_tready drops until the result is taken.
module touch_sample_qualifier_core (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // s_axis_tdata: raw_x, raw_y, raw_z (lowest bits first), zero padded
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  input  logic [tsq_pkg::InDataBits-1:0]  s_axis_tdata,
  // m_axis_tdata: out_x, out_y, out_z, region (lowest bits first), zero padded
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  output logic [tsq_pkg::OutDataBits-1:0] m_axis_tdata,
  // m_axis_tuser: reported
  output logic                            m_axis_tuser,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [tsq_pkg::AddrBits-1:0]    paddr,
  input  logic [tsq_pkg::ApbDataBits-1:0] pwdata,
  output logic [tsq_pkg::ApbDataBits-1:0] prdata,
  output logic                            pready
);
  import tsq_pkg::*;

  cfg_t cfg;

  tsq_cfg_regs u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // True when v lies outside c - tol .. c + tol; one extra bit keeps it exact.
  function automatic logic outside(sample_t v, sample_t c, sample_t tol);
    logic [SampleBits:0] v_hi, c_hi;
    v_hi = {1'b0, v} + {1'b0, tol};
    c_hi = {1'b0, c} + {1'b0, tol};
    return (v_hi < {1'b0, c}) || ({1'b0, v} > c_hi);
  endfunction

  // Input stage
  logic    in_valid_q;
  sample_t in_x_q, in_y_q, in_z_q;
  logic    advance;

  // Qualifier state
  sample_t start_x_q, start_y_q, start_z_q;
  hold_t   run_count_q, run_count_d;
  logic    latch_start;

  // Result stage
  logic    out_valid_q;
  logic    out_rep_q, out_rep_d;
  sample_t out_x_q, out_y_q, out_z_q, out_x_d, out_y_d, out_z_d;
  region_e out_region_q, out_region_d;

  // Clamped sample and window checks
  sample_t cx, cy, cz;
  logic    any_out;
  quot_t   qx, qy, qz;

  assign advance       = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  // Capture payload on accept only; it holds while the result side stalls.
  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_x_q <= s_axis_tdata[SampleBits-1:0];
      in_y_q <= s_axis_tdata[2*SampleBits-1:SampleBits];
      in_z_q <= s_axis_tdata[3*SampleBits-1:2*SampleBits];
    end
  end

  always_comb begin
    cx = (in_x_q < cfg.x_floor) ? '0 : in_x_q;
    cy = (in_y_q > cfg.y_ceiling) ? cfg.y_clamp_value : in_y_q;
    cz = (in_z_q <= cfg.z_floor) ? '0 : in_z_q;
    any_out = outside(cx, start_x_q, cfg.tol_x) ||
              outside(cy, start_y_q, cfg.tol_y) ||
              outside(cz, start_z_q, cfg.tol_z);
    qx = div100(cx);
    qy = div100(cy);
    qz = div100(cz);
  end

  // Climb the run while the sample is off the start point; report once the
  // count passes the hold limit, or when the counter sits at its top.
  always_comb begin
    latch_start  = any_out && (run_count_q == '0);
    run_count_d  = '0;
    out_rep_d    = 1'b0;
    out_x_d      = cx;
    out_y_d      = cy;
    out_z_d      = cz;
    out_region_d = RegionNone;
    if (any_out) begin
      if ((run_count_q <= cfg.hold_limit) && (32'(run_count_q) < RunCountMax)) begin
        run_count_d = run_count_q + hold_t'(1);
      end else begin
        out_rep_d    = 1'b1;
        out_x_d      = SampleBits'(qx);
        out_y_d      = SampleBits'(qy);
        out_z_d      = SampleBits'(qz);
        out_region_d = classify(qx, qy, qz);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_x_q   <= '0;
      start_y_q   <= '0;
      start_z_q   <= '0;
      run_count_q <= '0;
    end else if (advance) begin
      run_count_q <= run_count_d;
      if (latch_start) begin
        start_x_q <= cx;
        start_y_q <= cy;
        start_z_q <= cz;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_rep_q    <= out_rep_d;
      out_x_q      <= out_x_d;
      out_y_q      <= out_y_d;
      out_z_q      <= out_z_d;
      out_region_q <= out_region_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = out_rep_q;

  always_comb begin
    m_axis_tdata = '0;
    m_axis_tdata[SampleBits-1:0]                       = out_x_q;
    m_axis_tdata[2*SampleBits-1:SampleBits]            = out_y_q;
    m_axis_tdata[3*SampleBits-1:2*SampleBits]          = out_z_q;
    m_axis_tdata[3*SampleBits+RegionBits-1:3*SampleBits] = out_region_q;
  end

  // A report restarts the run.
  a_report_clears_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && out_rep_d) |=> (run_count_q == '0))
    else $error("run count not cleared after report");

  // A sample inside all windows resets the run.
  a_inside_clears_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && !any_out) |=> (run_count_q == '0) && !out_rep_q)
    else $error("in-window sample did not reset run");

  // Only reported results carry a region.
  a_region_needs_report: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_rep_q) |-> (out_region_q == RegionNone))
    else $error("region set on unreported result");

  // Reported values are divided and so stay small.
  a_report_divided: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_rep_q) |-> (out_x_q < SampleBits'(2 ** QuotBits)) &&
                                   (out_z_q < SampleBits'(2 ** QuotBits)))
    else $error("reported value not divided");

  // The start point moves only when a run begins.
  a_start_only_on_run_begin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(advance && latch_start) |=> $stable(start_x_q) && $stable(start_z_q))
    else $error("start point changed outside run begin");

endmodule

>>> bench/touch_sample_qualifier_core_checker.sv
// Checker for touch_sample_qualifier_core: watches the sample, result and APB
// channels, predicts each result and compares it. Depends on tsq_pkg.
module touch_sample_qualifier_core_checker (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            s_axis_tvalid_i,
  input  logic                            s_axis_tready_i,
  // s_axis_tdata_i: raw_x, raw_y, raw_z (lowest bits first), zero padded
  input  logic [tsq_pkg::InDataBits-1:0]  s_axis_tdata_i,
  input  logic                            m_axis_tvalid_i,
  input  logic                            m_axis_tready_i,
  // m_axis_tdata_i: out_x, out_y, out_z, region (lowest bits first), zero padded
  input  logic [tsq_pkg::OutDataBits-1:0] m_axis_tdata_i,
  // m_axis_tuser_i: reported
  input  logic                            m_axis_tuser_i,
  input  logic                            psel_i,
  input  logic                            penable_i,
  input  logic                            pwrite_i,
  input  logic [tsq_pkg::AddrBits-1:0]    paddr_i,
  input  logic [tsq_pkg::ApbDataBits-1:0] pwdata_i,
  input  logic [tsq_pkg::ApbDataBits-1:0] prdata_i,
  input  logic                            pready_i,
  output int                              errors_o,
  output int                              pending_o,
  output int                              results_o,
  output int                              reported_o,
  output int                              counter_top_o,
  output logic [6:0]                      regions_seen_o
);
  timeunit 1ns;
  timeprecision 1ps;
  import tsq_pkg::*;

  localparam int unsigned PrintCap = 40;

  typedef struct packed {
    logic    reported;
    sample_t x;
    sample_t y;
    sample_t z;
    region_e region;
  } touch_result_t;

  sample_t x_floor_q, y_ceiling_q, y_clamp_q, z_floor_q;
  sample_t tol_x_q, tol_y_q, tol_z_q;
  hold_t   hold_limit_q;
  sample_t start_x_q, start_y_q, start_z_q;
  hold_t   run_len_q;

  touch_result_t expected_q[$];

  task automatic report_mismatch(input string what, input logic [31:0] want,
                                 input logic [31:0] got);
    errors_o++;
    if (errors_o <= PrintCap)
      $display("%0t ns mismatch: %s expected 0x%0h got 0x%0h", $realtime, what, want, got);
  endtask

  function automatic logic beyond_window(sample_t v, sample_t centre, sample_t tol);
    int lo, hi;
    lo = int'(centre) - int'(tol);
    hi = int'(centre) + int'(tol);
    return !(lo <= int'(v) && int'(v) <= hi);
  endfunction

  // Classify divided values: down/up by x, right/center/left by y.
  function automatic region_e screen_region(sample_t qx, sample_t qy, sample_t qz);
    if (qz < 8) return RegionNone;
    if (qx <= 8) begin
      if (qy <= 10) return RegionRightDown;
      if (qy >= 16 && qy <= 23) return RegionCenterDown;
      if (qy >= 32) return RegionLeftDown;
    end else if (qx >= 33) begin
      if (qy <= 10) return RegionRightUp;
      if (qy >= 16 && qy <= 23) return RegionCenterUp;
      if (qy >= 32) return RegionLeftUp;
    end
    return RegionNone;
  endfunction

  // Clamp, window against the latched start point, advance or close the run.
  task automatic qualify(input sample_t rx, input sample_t ry, input sample_t rz,
                         output touch_result_t res);
    sample_t x, y, z;
    x = (rx < x_floor_q) ? '0 : rx;
    y = (ry > y_ceiling_q) ? y_clamp_q : ry;
    z = (rz <= z_floor_q) ? '0 : rz;
    res.reported = 1'b0;
    res.region   = RegionNone;
    if (beyond_window(x, start_x_q, tol_x_q) || beyond_window(y, start_y_q, tol_y_q) ||
        beyond_window(z, start_z_q, tol_z_q)) begin
      if (run_len_q == 0) begin
        start_x_q = x;
        start_y_q = y;
        start_z_q = z;
      end
      if (run_len_q <= hold_limit_q && run_len_q != hold_t'(RunCountMax)) begin
        run_len_q++;
      end else begin
        if (run_len_q == hold_t'(RunCountMax)) counter_top_o++;
        run_len_q    = '0;
        x            = x / 100;
        y            = y / 100;
        z            = z / 100;
        res.reported = 1'b1;
        res.region   = screen_region(x, y, z);
      end
    end else begin
      run_len_q = '0;
    end
    res.x = x;
    res.y = y;
    res.z = z;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    reg_idx_e      idx;
    logic [31:0]   stored;
    touch_result_t want, got;
    if (!rst_ni) begin
      x_floor_q      = sample_t'(XFloorRst);
      y_ceiling_q    = sample_t'(YCeilingRst);
      y_clamp_q      = sample_t'(YClampRst);
      z_floor_q      = sample_t'(ZFloorRst);
      tol_x_q        = sample_t'(TolXRst);
      tol_y_q        = sample_t'(TolYRst);
      tol_z_q        = sample_t'(TolZRst);
      hold_limit_q   = hold_t'(HoldLimitRst);
      start_x_q      = '0;
      start_y_q      = '0;
      start_z_q      = '0;
      run_len_q      = '0;
      expected_q.delete();
      errors_o       = 0;
      pending_o      = 0;
      results_o      = 0;
      reported_o     = 0;
      counter_top_o  = 0;
      regions_seen_o = '0;
    end else begin
      if (psel_i && penable_i && pready_i) begin
        idx = reg_idx_e'(paddr_i[AddrBits-1:2]);
        case (idx)
          RegXFloor: begin
            if (pwrite_i) x_floor_q = pwdata_i[SampleBits-1:0];
            stored = 32'(x_floor_q);
          end
          RegYCeiling: begin
            if (pwrite_i) y_ceiling_q = pwdata_i[SampleBits-1:0];
            stored = 32'(y_ceiling_q);
          end
          RegYClamp: begin
            if (pwrite_i) y_clamp_q = pwdata_i[SampleBits-1:0];
            stored = 32'(y_clamp_q);
          end
          RegZFloor: begin
            if (pwrite_i) z_floor_q = pwdata_i[SampleBits-1:0];
            stored = 32'(z_floor_q);
          end
          RegTolX: begin
            if (pwrite_i) tol_x_q = pwdata_i[SampleBits-1:0];
            stored = 32'(tol_x_q);
          end
          RegTolY: begin
            if (pwrite_i) tol_y_q = pwdata_i[SampleBits-1:0];
            stored = 32'(tol_y_q);
          end
          RegTolZ: begin
            if (pwrite_i) tol_z_q = pwdata_i[SampleBits-1:0];
            stored = 32'(tol_z_q);
          end
          default: begin
            if (pwrite_i) hold_limit_q = pwdata_i[HoldBits-1:0];
            stored = 32'(hold_limit_q);
          end
        endcase
        if (!pwrite_i && prdata_i !== stored) report_mismatch("register read", stored, prdata_i);
      end

      // Retire the oldest expectation before queuing the new sample.
      if (m_axis_tvalid_i && m_axis_tready_i) begin
        results_o++;
        if (expected_q.size() == 0) begin
          report_mismatch("result with no pending sample", '0, m_axis_tdata_i[31:0]);
        end else begin
          want = expected_q.pop_front();
          if (m_axis_tuser_i !== want.reported)
            report_mismatch("reported", 32'(want.reported), 32'(m_axis_tuser_i));
          if (m_axis_tdata_i[0 +: SampleBits] !== want.x)
            report_mismatch("out_x", 32'(want.x), 32'(m_axis_tdata_i[0 +: SampleBits]));
          if (m_axis_tdata_i[SampleBits +: SampleBits] !== want.y)
            report_mismatch("out_y", 32'(want.y),
                            32'(m_axis_tdata_i[SampleBits +: SampleBits]));
          if (m_axis_tdata_i[2*SampleBits +: SampleBits] !== want.z)
            report_mismatch("out_z", 32'(want.z),
                            32'(m_axis_tdata_i[2*SampleBits +: SampleBits]));
          if (m_axis_tdata_i[3*SampleBits +: RegionBits] !== want.region)
            report_mismatch("region", 32'(want.region),
                            32'(m_axis_tdata_i[3*SampleBits +: RegionBits]));
          if ((m_axis_tdata_i >> (3*SampleBits + RegionBits)) !== '0)
            report_mismatch("tdata padding", '0,
                            32'(m_axis_tdata_i >> (3*SampleBits + RegionBits)));
        end
      end

      if (s_axis_tvalid_i && s_axis_tready_i) begin
        qualify(s_axis_tdata_i[0 +: SampleBits], s_axis_tdata_i[SampleBits +: SampleBits],
                s_axis_tdata_i[2*SampleBits +: SampleBits], got);
        expected_q.push_back(got);
        if (got.reported) begin
          reported_o++;
          regions_seen_o[got.region] = 1'b1;
        end
      end
      pending_o = expected_q.size();
    end
  end

endmodule

>>> bench/touch_sample_qualifier_core_test.sv
// Testbench top for touch_sample_qualifier_core: drives samples, APB register
// settings and result back-pressure, and gives the verdict. Depends on tsq_pkg,
// the core and touch_sample_qualifier_core_checker.
module touch_sample_qualifier_core_test;
  timeunit 1ns;
  timeprecision 1ps;
  import tsq_pkg::*;

  localparam int IdlePercent   = 21;
  localparam int HoldOffCycles = 64;
  localparam int DrainCycles   = 8;
  // Longest quiet stretch of a correct run is the receiver hold-off plus a
  // register phase; take that many times over.
  localparam int QuietLimit    = 4000;
  localparam int SampleMax     = 2 ** SampleBits - 1;

  logic                   clk_i         = 1'b0;
  logic                   rst_ni        = 1'b0;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  // s_axis_tdata: raw_x, raw_y, raw_z (lowest bits first), zero padded
  logic [InDataBits-1:0]  s_axis_tdata  = '0;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  // m_axis_tdata: out_x, out_y, out_z, region (lowest bits first), zero padded
  logic [OutDataBits-1:0] m_axis_tdata;
  // m_axis_tuser: reported
  logic                   m_axis_tuser;
  logic                   psel          = 1'b0;
  logic                   penable       = 1'b0;
  logic                   pwrite        = 1'b0;
  logic [AddrBits-1:0]    paddr         = '0;
  logic [ApbDataBits-1:0] pwdata        = '0;
  logic [ApbDataBits-1:0] prdata;
  logic                   pready;

  logic       sample_taken;
  int         errors, pending, results, reported, counter_top;
  logic [6:0] regions_seen;

  int samples_sent  = 0;
  int quiet_cycles  = 0;
  int settings_used = 1;
  bit steady        = 1'b0;   // no idling on either side while set
  int holdoff_asked = 0;
  int holdoff_seen  = 0;
  int hold_left     = 0;
  int holdoff_item  = -1;
  int pause_item    = -1;

  // Current thresholds, used to aim stimulus at the clamp boundaries.
  int floor_x_now   = XFloorRst;
  int ceiling_y_now = YCeilingRst;
  int floor_z_now   = ZFloorRst;

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  touch_sample_qualifier_core DUT (.*);

  touch_sample_qualifier_core_checker u_checker (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid),
    .s_axis_tready_i (s_axis_tready),
    .s_axis_tdata_i  (s_axis_tdata),
    .m_axis_tvalid_i (m_axis_tvalid),
    .m_axis_tready_i (m_axis_tready),
    .m_axis_tdata_i  (m_axis_tdata),
    .m_axis_tuser_i  (m_axis_tuser),
    .psel_i          (psel),
    .penable_i       (penable),
    .pwrite_i        (pwrite),
    .paddr_i         (paddr),
    .pwdata_i        (pwdata),
    .prdata_i        (prdata),
    .pready_i        (pready),
    .errors_o        (errors),
    .pending_o       (pending),
    .results_o       (results),
    .reported_o      (reported),
    .counter_top_o   (counter_top),
    .regions_seen_o  (regions_seen)
  );

  // Record each sample handshake so the sender can see it at the next falling edge.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sample_taken <= 1'b0;
    end else begin
      sample_taken <= s_axis_tvalid & s_axis_tready;
    end
  end

  // Watchdog: end the run when no request moves on any channel for too long.
  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (psel && penable)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles == QuietLimit) begin
        $display("No request moved for %0d cycles, %0d results still due.",
                 QuietLimit, pending);
        $display("touch_sample_qualifier_core_test: FAIL");
        $finish;
      end
    end
  end

  // Result side: random back-pressure, a long hold-off on request, none while steady.
  always @(negedge clk_i) begin
    if (holdoff_seen != holdoff_asked) begin
      holdoff_seen = holdoff_asked;
      hold_left    = HoldOffCycles;
    end
    if (hold_left > 0) begin
      hold_left--;
      m_axis_tready <= 1'b0;
    end else if (steady) begin
      m_axis_tready <= 1'b1;
    end else begin
      m_axis_tready <= ($urandom_range(99, 0) >= IdlePercent);
    end
  end

  // Drop valid, wait for every outstanding result, then idle for as long as extra asks.
  task automatic settle(input int extra);
    s_axis_tvalid <= 1'b0;
    do @(negedge clk_i); while (pending != 0);
    repeat (extra) @(negedge clk_i);
  endtask

  // Offer one sample and hold it until it is accepted.
  task automatic send_sample(input sample_t x, input sample_t y, input sample_t z);
    if (samples_sent == pause_item) settle(DrainCycles);
    if (samples_sent == holdoff_item) holdoff_asked++;
    if (!steady) begin
      while ($urandom_range(99, 0) < IdlePercent) begin
        s_axis_tvalid <= 1'b0;
        @(negedge clk_i);
      end
    end
    s_axis_tdata  <= InDataBits'({z, y, x});
    s_axis_tvalid <= 1'b1;
    do @(negedge clk_i); while (!sample_taken);
    samples_sent++;
  endtask

  // One APB transfer: setup, access, then an idle phase.
  task automatic apb_access(input logic write, input reg_idx_e idx,
                            input logic [ApbDataBits-1:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= write;
    paddr   <= {idx, 2'b00};
    pwdata  <= data;
    @(negedge clk_i);
    penable <= 1'b1;
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(negedge clk_i);
  endtask

  // Write every register (junk in the unused upper bits) and read each back.
  task automatic configure(input int unsigned xf, input int unsigned yc, input int unsigned yv,
                           input int unsigned zf, input int unsigned tx, input int unsigned ty,
                           input int unsigned tz, input int unsigned hl);
    int unsigned            vals[NumRegs];
    logic [ApbDataBits-1:0] mask;
    reg_idx_e               idx;
    vals[RegXFloor]    = xf;
    vals[RegYCeiling]  = yc;
    vals[RegYClamp]    = yv;
    vals[RegZFloor]    = zf;
    vals[RegTolX]      = tx;
    vals[RegTolY]      = ty;
    vals[RegTolZ]      = tz;
    vals[RegHoldLimit] = hl;
    settle(DrainCycles);
    for (int i = 0; i < NumRegs; i++) begin
      idx  = reg_idx_e'(i);
      mask = (idx == RegHoldLimit) ? (32'd1 << HoldBits) - 1 : (32'd1 << SampleBits) - 1;
      apb_access(1'b1, idx, (vals[idx] & mask) | ($urandom & ~mask));
      apb_access(1'b0, idx, '0);
    end
    floor_x_now   = xf;
    ceiling_y_now = yc;
    floor_z_now   = zf;
    settings_used++;
  endtask

  // Pick from two bands of interest, around a threshold, an extreme, or anything.
  function automatic sample_t pick_field(input int lo_a, input int hi_a, input int lo_b,
                                         input int hi_b, input int thr);
    case ($urandom_range(5, 0))
      0:       return sample_t'($urandom_range(hi_a, lo_a));
      1:       return sample_t'($urandom_range(hi_b, lo_b));
      2:       return sample_t'($urandom_range(thr > SampleMax - 3 ? SampleMax : thr + 3,
                                               thr < 3 ? 0 : thr - 3));
      3:       return $urandom_range(1, 0) ? '1 : '0;
      default: return sample_t'($urandom);
    endcase
  endfunction

  // Bands aim at the screen regions after division: x down/up, y center/left, firm z.
  task automatic fresh_sample(output sample_t x, output sample_t y, output sample_t z);
    x = pick_field(0, 899, 3300, SampleMax, floor_x_now);
    y = pick_field(1600, 2399, 3200, SampleMax, ceiling_y_now);
    z = pick_field(800, SampleMax, 1500, SampleMax, floor_z_now);
  endtask

  function automatic sample_t jitter(input sample_t v);
    int t;
    t = int'(v) + $urandom_range(60, 0) - 30;
    return sample_t'(t < 0 ? 0 : (t > SampleMax ? SampleMax : t));
  endfunction

  // Touch bursts: a head sample, then followers that mostly move away from it
  // (growing the run), sometimes return to it or wobble near it.
  task automatic random_run(input int count, input int max_follow);
    sample_t hx, hy, hz, fx, fy, fz;
    int      stop, follow, roll;
    stop = samples_sent + count;
    while (samples_sent < stop) begin
      fresh_sample(hx, hy, hz);
      send_sample(hx, hy, hz);
      follow = $urandom_range(max_follow, 0);
      for (int j = 0; j < follow && samples_sent < stop; j++) begin
        roll = $urandom_range(99, 0);
        if (roll < 8) begin
          send_sample(hx, hy, hz);
        end else if (roll < 14) begin
          send_sample(jitter(hx), jitter(hy), jitter(hz));
        end else begin
          fresh_sample(fx, fy, fz);
          send_sample(fx, fy, fz);
        end
      end
    end
  endtask

  initial begin
    repeat (2) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Directed: extremes; x below and at its floor, y and z at and just above theirs.
    send_sample('0, '0, '0);
    send_sample('1, '1, '1);
    send_sample(sample_t'(XFloorRst - 1), 12'd1000, 12'd1000);
    send_sample(sample_t'(XFloorRst), 12'd1000, 12'd1000);
    send_sample(12'd2000, sample_t'(YCeilingRst), 12'd2000);
    send_sample(12'd2000, sample_t'(YCeilingRst + 1), 12'd2000);
    send_sample(12'd3000, 12'd3000, sample_t'(ZFloorRst));
    send_sample(12'd3000, 12'd3000, sample_t'(ZFloorRst + 1));
    // Repeat a sample: the second lands inside its own window and ends the run.
    send_sample(12'd3500, 12'd2000, 12'd1000);
    send_sample(12'd3500, 12'd2000, 12'd1000);
    // Full run to a report: a head, then followers far from it in x.
    send_sample(12'd700, 12'd150, 12'd3000);
    for (int i = 0; i < 7; i++) send_sample(sample_t'(3400 + 10 * i), sample_t'(2000 + 10 * i),
                                            12'd900);

    // Reset settings, with a long result hold-off and a full drain pause.
    holdoff_item = samples_sent + 40;
    pause_item   = samples_sent + 90;
    random_run(150, 18);

    // Lower extreme: only y clamps (to zero), zero windows, report every second sample.
    configure(0, 0, 0, 0, 0, 0, 0, 0);
    random_run(100, 12);

    // Upper extreme: z always clamps, x below its top, y never; windows span the range.
    configure(SampleMax, SampleMax, SampleMax, SampleMax, SampleMax, SampleMax, SampleMax,
              2 ** HoldBits - 1);
    random_run(60, 12);

    // Longest run with tight windows, no idling on either side.
    configure(520, 3600, 100, 300, 20, 20, 20, 2 ** HoldBits - 1);
    steady = 1'b1;
    random_run(150, 20);
    steady = 1'b0;

    repeat (3) begin
      configure($urandom_range(1000, 0), $urandom_range(SampleMax, 2000),
                $urandom_range(SampleMax, 0), $urandom_range(1000, 0),
                $urandom_range(300, 0), $urandom_range(300, 0), $urandom_range(300, 0),
                $urandom_range(2 ** HoldBits - 1, 0));
      random_run(150, 18);
    end

    settle(DrainCycles);
    $display("Covered %0d samples under %0d register settings; %0d results checked, %0d reported.",
             samples_sent, settings_used, results, reported);
    $display("Regions reported (bit per region code) %07b; runs closed at the counter top: %0d.",
             regions_seen, counter_top);
    if (errors == 0 && pending == 0) begin
      $display("touch_sample_qualifier_core_test: PASS");
    end else begin
      $display("touch_sample_qualifier_core_test: FAIL");
    end
    $finish;
  end

endmodule
